// ===== rtl/cvote_pkg.sv =====
// shared widths, constants and defaults for the class label window vote block
`default_nettype none

package cvote_pkg;

  localparam int LABEL_W           = 8;
  localparam int CONF_W            = 16;
  localparam int UNL_W             = 32;
  localparam int DEF_WINDOW_DEPTH  = 16;
  localparam int DEF_LABEL_KINDS   = 16;

  localparam logic signed [LABEL_W-1:0] NO_LABEL = -8'sd1;
  localparam logic [CONF_W-1:0]         CONF_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/cvote_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module cvote_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cvote_div.sv =====
// bit-serial restoring divider for the q0.16 confidence, saturating at all ones
`default_nettype none

module cvote_div
  import cvote_pkg::*;
#(
  parameter int NUM_W = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [UNL_W:0]     den,
  output logic                    done,
  output logic      [CONF_W-1:0]  quo
);

  localparam int RW = UNL_W + 2;
  localparam int SW = $clog2(CONF_W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [UNL_W:0] den_r, den_nxt;
  logic [CONF_W-1:0] quo_r, quo_nxt;
  logic [RW-1:0] shl;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    shl      = {rem_r[RW-2:0], 1'b0};
    if (start) begin
      den_nxt = den;
      if (RW'(num) >= RW'(den)) begin
        quo_nxt  = CONF_MAX;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = RW'(num);
        quo_nxt  = '0;
        step_nxt = SW'(CONF_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (shl >= RW'(den_r)) begin
        rem_nxt = shl - RW'(den_r);
        quo_nxt = {quo_r[CONF_W-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[CONF_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/class_label_window_vote_top.sv =====
// top level of the sliding window class label vote
//
//   channel | ports                                  | direction
//   in      | in_valid, in_ready, in_class_label     | request in
//   out     | out_valid, out_ready, out_best_label,  | request out
//           | out_confidence                         |
//
// a request goes through the window update, argmax scan and divider as needed:
// the count memory has a single read port, so the argmax scan reads one count
// per cycle, and the divider produces one quotient bit per cycle.
// reset clears control, the fill level, head and no-label count, and the
// per-entry valid flags of the count memory at once; no clearing pass.
// a new request is taken while a finished result waits in the output register;
// the block stalls only when the next result is ready and the register is full.
`default_nettype none

module class_label_window_vote_top
  import cvote_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int LABEL_KINDS  = DEF_LABEL_KINDS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [LABEL_W-1:0] in_class_label,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [LABEL_W-1:0]      out_best_label,
  output logic        [CONF_W-1:0]       out_confidence
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = (LABEL_KINDS > 1) ? $clog2(LABEL_KINDS) : 1;
  localparam int IW = $clog2(LABEL_KINDS + 1);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OLD  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_NEW  = 3'd3;
  localparam logic [2:0] S_INC  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  function automatic logic lab_ok(input logic [LABEL_W-1:0] x);
    return !x[LABEL_W-1] && (x[LABEL_W-2:0] < (LABEL_W-1)'(LABEL_KINDS));
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [LABEL_W-1:0] lab_r, lab_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [UNL_W-1:0]   unl_r, unl_nxt;
  logic [LABEL_KINDS-1:0] cvld_r, cvld_nxt;
  logic               chit_r, chit_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [LW-1:0]      pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]      best_cnt_r, best_cnt_nxt;
  logic [LW-1:0]      best_id_r, best_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [LABEL_W-1:0] out_lab_r, out_lab_nxt;
  logic [CONF_W-1:0]  out_conf_r, out_conf_nxt;

  logic               full;
  logic               win_we, win_re;
  logic [AW-1:0]      win_waddr;
  logic [LABEL_W-1:0] win_rdata;
  logic               cnt_we, cnt_re;
  logic [LW-1:0]      cnt_waddr, cnt_raddr;
  logic [CW-1:0]      cnt_wdata, cnt_rdata, cnt_rd;
  logic               div_start, div_done;
  logic [CONF_W-1:0]  div_quo;
  logic [UNL_W:0]     den;

  assign full   = (fill_r == FW'(WINDOW_DEPTH));
  assign cnt_rd = chit_r ? cnt_rdata : '0;
  assign den    = (UNL_W+1)'(WINDOW_DEPTH) + {1'b0, unl_r};

  cvote_ram #(.W(LABEL_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (lab_r),
    .re    (win_re),
    .raddr (head_r),
    .rdata (win_rdata)
  );

  cvote_ram #(.W(CW), .DEPTH(LABEL_KINDS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  cvote_div #(.NUM_W(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (best_cnt_r),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    lab_nxt       = lab_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    unl_nxt       = unl_r;
    cvld_nxt      = cvld_r;
    chit_nxt      = chit_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    best_cnt_nxt  = best_cnt_r;
    best_id_nxt   = best_id_r;
    out_valid_nxt = out_valid_r;
    out_lab_nxt   = out_lab_r;
    out_conf_nxt  = out_conf_r;
    in_ready      = 1'b0;
    win_we        = 1'b0;
    win_re        = 1'b0;
    win_waddr     = full ? head_r : fill_r[AW-1:0];
    cnt_we        = 1'b0;
    cnt_re        = 1'b0;
    cnt_waddr     = lab_r[LW-1:0];
    cnt_raddr     = lab_r[LW-1:0];
    cnt_wdata     = CW'(cnt_rd + 1'b1);
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lab_nxt      = in_class_label;
          rd_idx_nxt   = '0;
          pend_nxt     = 1'b0;
          best_cnt_nxt = '0;
          best_id_nxt  = '0;
          if (in_class_label == NO_LABEL) begin
            if (unl_r != '1) begin
              unl_nxt = unl_r + 1'b1;
            end
            state_nxt = S_SCAN;
          end else if (full) begin
            win_re    = 1'b1;
            state_nxt = S_OLD;
          end else begin
            state_nxt = S_NEW;
          end
        end
      end
      S_OLD: begin
        if (lab_ok(win_rdata)) begin
          cnt_re    = 1'b1;
          cnt_raddr = win_rdata[LW-1:0];
          chit_nxt  = cvld_r[win_rdata[LW-1:0]];
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_NEW;
        end
      end
      S_DEC: begin
        if (cnt_rd != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = win_rdata[LW-1:0];
          cnt_wdata = CW'(cnt_rd - 1'b1);
          cvld_nxt[win_rdata[LW-1:0]] = 1'b1;
        end
        state_nxt = S_NEW;
      end
      S_NEW: begin
        win_we = 1'b1;
        if (full) begin
          head_nxt = (head_r == AW'(WINDOW_DEPTH - 1)) ? '0 : AW'(head_r + 1'b1);
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        if (lab_ok(lab_r)) begin
          cnt_re    = 1'b1;
          chit_nxt  = cvld_r[lab_r[LW-1:0]];
          state_nxt = S_INC;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_INC: begin
        cnt_we = 1'b1;
        cvld_nxt[lab_r[LW-1:0]] = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pend_r && (cnt_rd > best_cnt_r)) begin
          best_cnt_nxt = cnt_rd;
          best_id_nxt  = pend_idx_r;
        end
        if (rd_idx_r < IW'(LABEL_KINDS)) begin
          cnt_re       = 1'b1;
          cnt_raddr    = rd_idx_r[LW-1:0];
          chit_nxt     = cvld_r[rd_idx_r[LW-1:0]];
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[LW-1:0];
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (best_cnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (best_cnt_r == '0) begin
            out_lab_nxt  = NO_LABEL;
            out_conf_nxt = '0;
          end else begin
            out_lab_nxt  = LABEL_W'(best_id_r);
            out_conf_nxt = div_quo;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      unl_r       <= '0;
      cvld_r      <= '0;
      chit_r      <= 1'b0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      unl_r       <= unl_nxt;
      cvld_r      <= cvld_nxt;
      chit_r      <= chit_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lab_r      <= lab_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_id_r  <= best_id_nxt;
    out_lab_r  <= out_lab_nxt;
    out_conf_r <= out_conf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_label = out_lab_r;
  assign out_confidence = out_conf_r;

endmodule

`default_nettype wire
